@@ hdl/hppt_pkg.sv @@
package hppt_pkg;

  // Table geometry
  localparam int unsigned NumPages  = 16;
  localparam int unsigned PageWords = 16;
  localparam int unsigned PageIdxW  = $clog2(NumPages);
  localparam int unsigned OffW      = $clog2(PageWords);
  localparam int unsigned AddrW     = PageIdxW + OffW;
  localparam int unsigned NumWords  = NumPages * PageWords;
  localparam int unsigned CntW      = $clog2(NumPages + 1);

  // Field widths
  localparam int unsigned ReqW    = 3;
  localparam int unsigned PidW    = 32;
  localparam int unsigned VaddrW  = 10;
  localparam int unsigned DataW   = 32;
  localparam int unsigned BucketW = 4;

  typedef enum logic [ReqW-1:0] {
    REQ_INSERT = 3'd0,
    REQ_SEARCH = 3'd1,
    REQ_WRITE  = 3'd2,
    REQ_READ   = 3'd3,
    REQ_DELETE = 3'd4
  } req_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;
    logic lookup;
    logic access;
    logic load_out;
  } hppt_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic out_free;
  } hppt_sts_t;

endpackage

@@ hdl/hppt_if.sv @@
interface hppt_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [31:0]        pid;
  logic [9:0]         vaddr;
  logic signed [31:0] wdata;

  modport source (output valid, req_type, pid, vaddr, wdata, input ready);
  modport sink (input valid, req_type, pid, vaddr, wdata, output ready);
endinterface

interface hppt_rsp_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic [3:0]         bucket;
  logic signed [31:0] rdata;

  modport source (output valid, ok, bucket, rdata, input ready);
  modport sink (input valid, ok, bucket, rdata, output ready);
endinterface

@@ hdl/hashed_process_page_table_core.sv @@
// Hashed process page table: 16 pages of 16 words, one page per process ID.
// Channels: req_i (sink) takes req_type, pid, vaddr, wdata; rsp_o (source)
// returns ok, bucket, rdata. A transfer happens on a clock edge with valid
// and ready both high. Exactly one response follows every request, in order.
// The controller takes one request at a time through the sequence
// capture -> table match and free-page pick -> page update and word store
// access (one port, registered read) -> output register load; a new request
// is taken only once the last one has loaded the output register.
// The tag match compares all 16 owner entries in parallel.
// Reset (rst_ni low, asynchronous) frees every page, zeroes the page count,
// marks every word as never written (reads as zero) and empties the output
// register. No clearing pass is needed; requests are taken right away.
// Receiver stall: the output register holds the response while rsp_o.ready
// is low. The next request is still taken and processed meanwhile; it waits
// in its last step until the output register frees up, and req_i.ready stays
// low until then.
module hashed_process_page_table_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  hppt_req_if.sink   req_i,
  hppt_rsp_if.source rsp_o
);
  import hppt_pkg::*;

  hppt_cmd_t cmd;   // controller commands
  hppt_sts_t sts;   // datapath status
  logic      in_ready;

  hppt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  assign req_i.ready = in_ready;

  hppt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_type_i  (req_i.req_type),
    .pid_i       (req_i.pid),
    .vaddr_i     (req_i.vaddr),
    .wdata_i     (req_i.wdata),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .ok_o        (rsp_o.ok),
    .bucket_o    (rsp_o.bucket),
    .rdata_o     (rsp_o.rdata)
  );

  // A request transfer starts the lookup in the next cycle
  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && in_ready |=> cmd.lookup)
    else $error("lookup did not follow request transfer");

  // Lookup is always followed by the access step
  a_lookup_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.lookup |=> cmd.access)
    else $error("access did not follow lookup");

  // The output register is never overwritten while it holds an untaken response
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!rsp_o.valid || rsp_o.ready))
    else $error("response overwritten");

  // No new request is taken while a request is in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.lookup || cmd.access) |-> !in_ready)
    else $error("request taken while busy");

endmodule

@@ hdl/hppt_ctrl.sv @@
module hppt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output hppt_pkg::hppt_cmd_t cmd_o,
  input  hppt_pkg::hppt_sts_t sts_i
);
  import hppt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_ACC  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = S_LOOK;
      end
      S_LOOK: begin
        cmd_o.lookup = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.access = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/hppt_dp.sv @@
module hppt_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hppt_pkg::hppt_cmd_t cmd_i,
  output hppt_pkg::hppt_sts_t sts_o,
  input  logic [2:0]          req_type_i,
  input  logic [31:0]         pid_i,
  input  logic [9:0]          vaddr_i,
  input  logic signed [31:0]  wdata_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                ok_o,
  output logic [3:0]          bucket_o,
  output logic signed [31:0]  rdata_o
);
  import hppt_pkg::*;

  // Captured request
  logic [ReqW-1:0]   req_type_q;
  logic [PidW-1:0]   pid_q;
  logic [VaddrW-1:0] vaddr_q;
  logic [DataW-1:0]  wdata_q;

  // Page table
  logic [NumPages-1:0] busy_q;
  logic [PidW-1:0]     owner_q [NumPages];
  logic [CntW-1:0]     cnt_q;

  // Lookup results
  logic                hit_d, hit_q;
  logic [PageIdxW-1:0] hit_page_d, hit_page_q;
  logic [PageIdxW-1:0] low_free;
  logic [PageIdxW-1:0] free_page_d, free_page_q;
  logic                full_q;
  logic [PageIdxW-1:0] bucket;

  // Word store
  logic [DataW-1:0]    mem_q [NumWords];
  logic [NumWords-1:0] ent_vld_q;
  logic [DataW-1:0]    mem_rd_q;
  logic                rd_vld_q;
  logic [AddrW-1:0]    idx;

  // Access decision
  logic ok_d, ok_q;
  logic in_page;
  logic do_ins, do_del, do_wr;

  // Output register
  logic                out_valid_q;
  logic                out_ok_q;
  logic [BucketW-1:0]  out_bucket_q;
  logic [DataW-1:0]    out_rdata_q;

  assign bucket = pid_q[PageIdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_type_q <= req_type_i;
      pid_q      <= pid_i;
      vaddr_q    <= vaddr_i;
      wdata_q    <= wdata_i;
    end
  end

  // Parallel tag match and free-page pick (home bucket, else lowest free page); the lowest index wins
  always_comb begin
    hit_d      = 1'b0;
    hit_page_d = '0;
    low_free   = '0;
    for (int p = NumPages - 1; p >= 0; p--) begin
      if (busy_q[p] && (owner_q[p] == pid_q)) begin
        hit_d      = 1'b1;
        hit_page_d = PageIdxW'(p);
      end
      if (!busy_q[p]) low_free = PageIdxW'(p);
    end
    free_page_d = busy_q[bucket] ? low_free : bucket;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q       <= hit_d;
      hit_page_q  <= hit_page_d;
      free_page_q <= free_page_d;
      full_q      <= (cnt_q >= CntW'(NumPages));
    end
  end

  assign in_page = (vaddr_q[VaddrW-1:OffW] == '0);
  assign idx     = {hit_page_q, vaddr_q[OffW-1:0]};

  always_comb begin
    ok_d = 1'b0;
    case (req_type_q) inside
      REQ_INSERT:             ok_d = !full_q && !hit_q;
      REQ_SEARCH:             ok_d = hit_q;
      REQ_WRITE, REQ_READ:    ok_d = in_page && hit_q;
      REQ_DELETE:             ok_d = hit_q;
      default:                ok_d = 1'b0;
    endcase
  end

  assign do_ins = cmd_i.access && ok_d && (req_type_q == REQ_INSERT);
  assign do_del = cmd_i.access && ok_d && (req_type_q == REQ_DELETE);
  assign do_wr  = cmd_i.access && ok_d && (req_type_q == REQ_WRITE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= '0;
      cnt_q     <= '0;
      ent_vld_q <= '0;
    end else begin
      if (do_ins) begin
        busy_q[free_page_q] <= 1'b1;
        cnt_q               <= cnt_q + CntW'(1);
      end
      if (do_del) begin
        busy_q[hit_page_q] <= 1'b0;
        if (cnt_q != '0) cnt_q <= cnt_q - CntW'(1);
      end
      if (do_wr) ent_vld_q[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_ins) owner_q[free_page_q] <= pid_q;
    if (cmd_i.access) ok_q <= ok_d;
  end

  // Word store: one registered read per request, plus the store for a write request
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[idx] <= wdata_q;
    if (cmd_i.access) begin
      mem_rd_q <= mem_q[idx];
      rd_vld_q <= ent_vld_q[idx];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_ok_q     <= ok_q;
      out_bucket_q <= BucketW'(bucket);
      out_rdata_q  <= (ok_q && (req_type_q == REQ_READ) && rd_vld_q) ? mem_rd_q : '0;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign ok_o           = out_ok_q;
  assign bucket_o       = out_bucket_q;
  assign rdata_o        = out_rdata_q;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

import hppt_pkg::*;

typedef struct packed {
  logic               ok;
  logic [BucketW-1:0] bucket;
  logic [DataW-1:0]   rdata;
} lookup_rsp_t;

// Shadow page table; predicts one response per request and checks the
// responses in order.
class page_table_scoreboard;
  bit                 page_taken [NumPages];
  logic [PidW-1:0]    page_pid   [NumPages];
  int unsigned        taken_count;
  logic [DataW-1:0]   word_mem   [NumWords];
  lookup_rsp_t        expected_rsp[$];
  int unsigned        accepted;
  int unsigned        mismatches;

  function new();
    foreach (page_taken[p]) begin
      page_taken[p] = 1'b0;
      page_pid[p]   = '0;
    end
    foreach (word_mem[w]) word_mem[w] = '0;
    taken_count = 0;
    accepted    = 0;
    mismatches  = 0;
  endfunction

  function int owner_page(logic [PidW-1:0] pid);
    for (int p = 0; p < NumPages; p++)
      if (page_taken[p] && page_pid[p] == pid) return p;
    return -1;
  endfunction

  function int lowest_free();
    for (int p = 0; p < NumPages; p++)
      if (!page_taken[p]) return p;
    return -1;
  endfunction

  function void note_request(logic [ReqW-1:0] op, logic [PidW-1:0] pid,
                             logic [VaddrW-1:0] vaddr, logic [DataW-1:0] wdata);
    lookup_rsp_t rsp;
    int          home;
    int          page;
    int          idx;
    home       = int'(pid % NumPages);
    rsp.ok     = 1'b0;
    rsp.bucket = BucketW'(home);
    rsp.rdata  = '0;
    case (op) inside
      REQ_INSERT: begin
        if (taken_count < NumPages && owner_page(pid) < 0) begin
          page = page_taken[home] ? lowest_free() : home;
          if (page >= 0) begin
            page_taken[page] = 1'b1;
            page_pid[page]   = pid;
            taken_count++;
            rsp.ok = 1'b1;
          end
        end
      end
      REQ_SEARCH: rsp.ok = (owner_page(pid) >= 0);
      REQ_WRITE, REQ_READ: begin
        page = owner_page(pid);
        if (vaddr < PageWords && page >= 0) begin
          idx = page * PageWords + int'(vaddr);
          if (op == REQ_WRITE) word_mem[idx] = wdata;
          else rsp.rdata = word_mem[idx];
          rsp.ok = 1'b1;
        end
      end
      REQ_DELETE: begin
        page = owner_page(pid);
        if (page >= 0) begin
          page_taken[page] = 1'b0;
          if (taken_count > 0) taken_count--;
          rsp.ok = 1'b1;
        end
      end
      default: ;
    endcase
    accepted++;
    expected_rsp = {expected_rsp, rsp};
  endfunction

  function void check_response(logic ok, logic [BucketW-1:0] bucket,
                               logic [DataW-1:0] rdata);
    lookup_rsp_t want;
    if (expected_rsp.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: response with nothing outstanding: ok %0b bucket %0d rdata %h",
                 $time, ok, bucket, rdata);
      return;
    end
    want = expected_rsp.pop_front();
    if (ok !== want.ok || bucket !== want.bucket || rdata !== want.rdata) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: response mismatch: ok %0b/%0b bucket %0d/%0d rdata %h/%h (exp/got)",
                 $time, want.ok, ok, want.bucket, bucket, want.rdata, rdata);
    end
  endfunction

  function int unsigned pending();
    return expected_rsp.size();
  endfunction
endclass

module tb_top;

  // Request codes past REQ_DELETE have no meaning; the block must answer
  // them with a failure and leave the table alone.
  localparam logic [ReqW-1:0] ReqFirstUnknown = ReqW'(REQ_DELETE + 1);
  localparam logic [ReqW-1:0] ReqLastUnknown  = '1;
  localparam int unsigned     PoolSize        = 24;
  localparam int unsigned     RandomItems     = 850;
  localparam int unsigned     PhaseLen        = 90;
  localparam int unsigned     HoldOffAt       = 300;   // transfers before long stall
  localparam int unsigned     HoldOffCycles   = 150;

  logic clk_i;
  logic rst_ni;

  hppt_req_if req_bus ();
  hppt_rsp_if rsp_bus ();

  hashed_process_page_table_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus.sink),
    .rsp_o  (rsp_bus.source)
  );

  page_table_scoreboard sb = new();

  logic [PidW-1:0] pid_pool [PoolSize];
  int unsigned     burst_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop; a correct run needs well under a tenth of this.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // Monitor: both channels sampled at the rising edge, before any flop or
  // driver update of that edge lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready)
        sb.note_request(req_bus.req_type, req_bus.pid, req_bus.vaddr, req_bus.wdata);
      if (rsp_bus.valid && rsp_bus.ready)
        sb.check_response(rsp_bus.ok, rsp_bus.bucket, rsp_bus.rdata);
    end
  end

  // Offer one request and hold it until the transfer. The sender runs in
  // bursts; at the end of a burst it may drop valid for a few cycles.
  // Valid is only lowered when a gap follows, so a back-to-back request
  // sees a single assignment per edge.
  task automatic send_request(input logic [ReqW-1:0] op, input logic [PidW-1:0] pid,
                              input logic [VaddrW-1:0] vaddr,
                              input logic [DataW-1:0] wdata);
    int unsigned gap;
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= op;
    req_bus.pid      <= pid;
    req_bus.vaddr    <= vaddr;
    req_bus.wdata    <= wdata;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Directed part: hash collision, duplicate, absent pid, off-page offset,
  // field extremes, unknown codes and stale data after page reuse.
  task automatic run_directed();
    send_request(REQ_INSERT, 32'h0000_0000, 10'd0, 32'h0);
    send_request(REQ_INSERT, 32'd16, 10'd0, 32'h0);            // bucket 0 taken
    send_request(REQ_WRITE,  32'd16, 10'd7, 32'h1234_5678);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 10'd0, 32'h0);     // bucket 15
    send_request(REQ_INSERT, 32'h0000_0000, 10'd0, 32'h0);     // duplicate
    send_request(REQ_SEARCH, 32'd16, 10'd0, 32'h0);
    send_request(REQ_SEARCH, 32'd5, 10'd0, 32'h0);             // absent
    send_request(REQ_WRITE,  32'h0000_0000, 10'd0, 32'h8000_0000);
    send_request(REQ_WRITE,  32'h0000_0000, 10'd15, 32'h7FFF_FFFF);
    send_request(REQ_READ,   32'h0000_0000, 10'd0, 32'hFFFF_FFFF);
    send_request(REQ_READ,   32'h0000_0000, 10'd15, 32'h0);
    send_request(REQ_READ,   32'hFFFF_FFFF, 10'd3, 32'h0);     // never written
    send_request(REQ_READ,   32'h0000_0000, 10'd16, 32'h0);    // off page
    send_request(REQ_WRITE,  32'h0000_0000, 10'd1023, 32'hFFFF_FFFF);
    send_request(REQ_READ,   32'd5, 10'd0, 32'h0);
    send_request(REQ_WRITE,  32'd5, 10'd0, 32'hDEAD_BEEF);
    send_request(REQ_DELETE, 32'd16, 10'd0, 32'h0);
    send_request(REQ_DELETE, 32'd16, 10'd0, 32'h0);            // already gone
    send_request(REQ_INSERT, 32'd48, 10'd0, 32'h0);            // reuses page 1
    send_request(REQ_READ,   32'd48, 10'd7, 32'h0);            // stale word
    for (int u = ReqFirstUnknown; u <= ReqLastUnknown; u++)
      send_request(ReqW'(u), 32'hA5A5_5A5A, 10'h3FF, 32'hFFFF_FFFF);
    send_request(REQ_SEARCH, 32'h0000_0000, 10'd0, 32'h0);
  endtask

  // Phases rotate: insert-heavy (fills the table), access-heavy, and
  // delete-heavy (drains it), so both full and empty tables come up often.
  function automatic logic [ReqW-1:0] pick_op(int unsigned phase);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll >= 97) return ReqFirstUnknown + ReqW'($urandom_range(0, 2));
    case (phase)
      0: begin
        if (roll < 45) return REQ_INSERT;
        if (roll < 55) return REQ_SEARCH;
        if (roll < 70) return REQ_WRITE;
        if (roll < 85) return REQ_READ;
      end
      1: begin
        if (roll < 15) return REQ_INSERT;
        if (roll < 25) return REQ_SEARCH;
        if (roll < 55) return REQ_WRITE;
        if (roll < 85) return REQ_READ;
      end
      default: begin
        if (roll < 10) return REQ_INSERT;
        if (roll < 20) return REQ_SEARCH;
        if (roll < 35) return REQ_WRITE;
        if (roll < 50) return REQ_READ;
      end
    endcase
    return REQ_DELETE;
  endfunction

  task automatic run_random(input int unsigned count);
    logic [ReqW-1:0]   op;
    logic [PidW-1:0]   pid;
    logic [VaddrW-1:0] vaddr;
    for (int unsigned i = 0; i < count; i++) begin
      op    = pick_op((i / PhaseLen) % 3);
      pid   = ($urandom_range(0, 9) == 0) ? $urandom : pid_pool[$urandom_range(0, PoolSize-1)];
      vaddr = ($urandom_range(0, 6) == 0) ? VaddrW'($urandom_range(0, 1023))
                                          : VaddrW'($urandom_range(0, PageWords-1));
      send_request(op, pid, vaddr, $urandom);
    end
  endtask

  // Main sequence: reset, directed, random, then drain.
  initial begin
    rst_ni           <= 1'b0;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= REQ_SEARCH;
    req_bus.pid      <= '0;
    req_bus.vaddr    <= '0;
    req_bus.wdata    <= '0;
    burst_left = 0;
    // Pool mixes random pids, a cluster sharing bucket 3 and small values,
    // so collisions and overflow to the lowest free page are frequent.
    for (int k = 0; k < PoolSize; k++) begin
      case (k % 3)
        0:       pid_pool[k] = $urandom;
        1:       pid_pool[k] = ($urandom & ~32'hF) | 32'h3;
        default: pid_pool[k] = k;
      endcase
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(RandomItems);
    req_bus.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);   // catch stray responses
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Response side: stalls follow a mix of patterns (always ready, toggle,
  // random, mostly stalled). Once, after enough transfers, it holds off
  // long enough for the block to back up and drop req ready.
  initial begin
    int unsigned mode;
    int unsigned span;
    bit          held_off;
    held_off = 1'b0;
    rsp_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held_off && sb.accepted >= HoldOffAt) begin
        held_off = 1'b1;
        rsp_bus.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 80);
      for (int unsigned c = 0; c < span; c++) begin
        case (mode)
          0:       rsp_bus.ready <= 1'b1;
          1:       rsp_bus.ready <= c[0];
          2:       rsp_bus.ready <= ($urandom_range(0, 9) < 7);
          default: rsp_bus.ready <= ((c % 8) >= 6);
        endcase
        @(posedge clk_i);
      end
    end
  end

endmodule
